/* rtl/rpr_pkg.sv */
// Shared types, constants and arithmetic helpers of the rational resampler.
package rpr_pkg;

    // Fixed field widths
    localparam int DATA_W     = 16;
    localparam int ACC_W      = 40;
    localparam int UP_W       = 6;
    localparam int DOWN_W     = 11;
    localparam int TAPS_W     = 9;
    localparam int PHASE_W    = 10;
    localparam int IDX_W      = 8;
    localparam int CFG_IDX_W  = 2;

    // Limits
    localparam int MAX_TAPS_DEF = 256;
    localparam int MAX_UP_DEF   = 32;
    localparam int MAX_DOWN     = 1024;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_UP_FACTOR   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DOWN_FACTOR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT   = 2'd2;

    // Input item kinds (carried on tuser)
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic hist_we;
        logic coef_we;
        logic issue;
        logic zero;
        logic acc_clear;
        logic out_load;
        logic last;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_taken;
    } status_t;

    // Round half up from Q10.30 sum to Q1.15 and saturate
    function automatic logic signed [DATA_W-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W:0]    biased;
        logic signed [ACC_W-15:0] q;
        logic signed [ACC_W-15:0] qmax;
        logic signed [ACC_W-15:0] qmin;
        biased = $signed({acc[ACC_W-1], acc}) + $signed((ACC_W+1)'(16384));
        q      = biased[ACC_W:15];
        qmax   = (ACC_W-14)'(2**(DATA_W-1) - 1);
        qmin   = -(ACC_W-14)'(2**(DATA_W-1));
        if (q > qmax)
            return qmax[DATA_W-1:0];
        else if (q < qmin)
            return qmin[DATA_W-1:0];
        else
            return q[DATA_W-1:0];
    endfunction

endpackage

/* rtl/rational_polyphase_resampler.sv */
// Rational polyphase resampler: up by U, FIR with loaded taps, down by D.
// A coefficient load or a sample push is taken only while idle; a push then walks the U
// phase positions, and each emitted output is summed by the single shared MAC reading
// one tap a cycle, then held until it is taken.
// Reset (async, active low) clears control, factors to 1, history reads as zero.
module rational_polyphase_resampler #(
    parameter int MAX_TAPS = rpr_pkg::MAX_TAPS_DEF,
    parameter int MAX_UP   = rpr_pkg::MAX_UP_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [rpr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rpr_pkg::DOWN_W-1:0]    cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [23:0]                   s_tdata,  // coef_index[7:0], value[23:8]
    input  logic                          s_tuser,  // opcode
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [15:0]                   m_tdata,  // out_sample[15:0]
    output logic                          m_tlast
);

    localparam int AW = $clog2(MAX_TAPS);

    rpr_pkg::cmd_t    cmd;
    rpr_pkg::status_t status;
    logic [AW-1:0]    hist_waddr;
    logic [AW-1:0]    hist_raddr;
    logic [AW-1:0]    coef_raddr;

    rpr_ctrl #(.MAX_TAPS(MAX_TAPS), .MAX_UP(MAX_UP)) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tuser    (s_tuser),
        .coef_index (s_tdata[7:0]),
        .s_tready   (s_tready),
        .status     (status),
        .cmd        (cmd),
        .hist_waddr (hist_waddr),
        .hist_raddr (hist_raddr),
        .coef_raddr (coef_raddr)
    );

    rpr_datapath #(.MAX_TAPS(MAX_TAPS)) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .hist_waddr (hist_waddr),
        .hist_raddr (hist_raddr),
        .coef_raddr (coef_raddr),
        .coef_index (s_tdata[7:0]),
        .value      (s_tdata[23:8]),
        .status     (status),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

/* rtl/rpr_ram.sv */
// Generic single write port, single read port RAM with registered read data.
module rpr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/rpr_datapath.sv */
// Datapath: coefficient and history stores, shared MAC and output register.
module rpr_datapath #(
    parameter int MAX_TAPS = rpr_pkg::MAX_TAPS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  rpr_pkg::cmd_t                   cmd,
    input  logic [$clog2(MAX_TAPS)-1:0]     hist_waddr,
    input  logic [$clog2(MAX_TAPS)-1:0]     hist_raddr,
    input  logic [$clog2(MAX_TAPS)-1:0]     coef_raddr,
    input  logic [rpr_pkg::IDX_W-1:0]       coef_index,
    input  logic [rpr_pkg::DATA_W-1:0]      value,
    output rpr_pkg::status_t                status,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [rpr_pkg::DATA_W-1:0]      m_tdata,
    output logic                            m_tlast
);

    localparam int AW = $clog2(MAX_TAPS);
    localparam int PW = 2 * rpr_pkg::DATA_W;

    logic [rpr_pkg::DATA_W-1:0]      coef_rd;
    logic [rpr_pkg::DATA_W-1:0]      hist_rd;
    logic                            s1_valid_reg;
    logic                            s1_zero_reg;
    logic                            s2_valid_reg;
    logic signed [PW-1:0]            prod_reg;
    logic signed [rpr_pkg::ACC_W-1:0] acc_reg;
    logic                            out_valid_reg;
    logic [rpr_pkg::DATA_W-1:0]      out_data_reg;
    logic                            out_last_reg;

    // Coefficient and sample history stores
    rpr_ram #(.WIDTH(rpr_pkg::DATA_W), .DEPTH(MAX_TAPS)) u_coef_ram (
        .clk   (clk),
        .we    (cmd.coef_we),
        .waddr (AW'(coef_index)),
        .wdata (value),
        .raddr (coef_raddr),
        .rdata (coef_rd)
    );

    rpr_ram #(.WIDTH(rpr_pkg::DATA_W), .DEPTH(MAX_TAPS)) u_hist_ram (
        .clk   (clk),
        .we    (cmd.hist_we),
        .waddr (hist_waddr),
        .wdata (value),
        .raddr (hist_raddr),
        .rdata (hist_rd)
    );

    // Pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= cmd.issue;
            s2_valid_reg <= s1_valid_reg;
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Multiply, accumulate, round
    always_ff @(posedge clk)
    begin
        s1_zero_reg <= cmd.zero;
        if (s1_zero_reg)
            prod_reg <= '0;
        else
            prod_reg <= $signed(coef_rd) * $signed(hist_rd);
        if (cmd.acc_clear)
            acc_reg <= '0;
        else if (s2_valid_reg)
            acc_reg <= acc_reg + rpr_pkg::ACC_W'(prod_reg);
        if (cmd.out_load)
        begin
            out_data_reg <= rpr_pkg::round_sat(acc_reg);
            out_last_reg <= cmd.last;
        end
    end

    assign status.out_taken = out_valid_reg & m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

/* rtl/rpr_ctrl.sv */
// Controller: configuration registers, phase and tap sequencing.
module rpr_ctrl #(
    parameter int MAX_TAPS = rpr_pkg::MAX_TAPS_DEF,
    parameter int MAX_UP   = rpr_pkg::MAX_UP_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [rpr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rpr_pkg::DOWN_W-1:0]        cfg_wdata,
    input  logic                              s_tvalid,
    input  logic                              s_tuser,
    input  logic [rpr_pkg::IDX_W-1:0]         coef_index,
    output logic                              s_tready,
    input  rpr_pkg::status_t                  status,
    output rpr_pkg::cmd_t                     cmd,
    output logic [$clog2(MAX_TAPS)-1:0]       hist_waddr,
    output logic [$clog2(MAX_TAPS)-1:0]       hist_raddr,
    output logic [$clog2(MAX_TAPS)-1:0]       coef_raddr
);

    localparam int AW = $clog2(MAX_TAPS);
    localparam int CW = AW + 1;
    localparam int MW = $clog2(MAX_TAPS + MAX_UP) + 1;

    typedef enum logic [2:0] {
        S_IDLE, S_PHASE, S_CALC, S_DRAIN, S_FINISH, S_EMIT
    } state_t;

    state_t                          state_reg, state_next;
    logic [rpr_pkg::UP_W-1:0]        up_reg;
    logic [rpr_pkg::DOWN_W-1:0]      down_reg;
    logic [rpr_pkg::TAPS_W-1:0]      taps_reg;
    logic [AW-1:0]                   head_reg, head_next;
    logic [CW-1:0]                   fill_reg, fill_next;
    logic [rpr_pkg::PHASE_W-1:0]     phase_reg, phase_next;
    logic [rpr_pkg::UP_W-1:0]        p_reg, p_next;
    logic [MW-1:0]                   m_reg, m_next;
    logic [AW-1:0]                   k_reg, k_next;

    logic [rpr_pkg::UP_W-1:0]        u_eff;
    logic [rpr_pkg::DOWN_W-1:0]      d_eff;
    logic [CW-1:0]                   t_eff;
    logic [rpr_pkg::PHASE_W-1:0]     phase_adv;
    logic                            last_pos;
    logic [rpr_pkg::DOWN_W-1:0]      remaining;

    // Effective factors after clamping
    always_comb
    begin
        if (up_reg == '0)
            u_eff = rpr_pkg::UP_W'(1);
        else if (32'(up_reg) > MAX_UP)
            u_eff = rpr_pkg::UP_W'(MAX_UP);
        else
            u_eff = up_reg;
        if (down_reg == '0)
            d_eff = rpr_pkg::DOWN_W'(1);
        else if (32'(down_reg) > rpr_pkg::MAX_DOWN)
            d_eff = rpr_pkg::DOWN_W'(rpr_pkg::MAX_DOWN);
        else
            d_eff = down_reg;
        if (32'(taps_reg) > MAX_TAPS)
            t_eff = CW'(MAX_TAPS);
        else
            t_eff = CW'(taps_reg);
    end

    // Decimation phase step, last position and last-output test
    assign phase_adv = ((rpr_pkg::DOWN_W'(phase_reg) + rpr_pkg::DOWN_W'(1)) >= d_eff)
                       ? '0 : phase_reg + rpr_pkg::PHASE_W'(1);
    assign last_pos  = (p_reg == u_eff - rpr_pkg::UP_W'(1));
    assign remaining = rpr_pkg::DOWN_W'(u_eff) - rpr_pkg::DOWN_W'(1) - rpr_pkg::DOWN_W'(p_reg);

    assign hist_waddr = head_reg + AW'(1);
    assign hist_raddr = head_reg - k_reg;
    assign coef_raddr = m_reg[AW-1:0];

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        fill_next  = fill_reg;
        phase_next = phase_reg;
        p_next     = p_reg;
        m_next     = m_reg;
        k_next     = k_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    if (s_tuser == rpr_pkg::OP_LOAD)
                    begin
                        cmd.coef_we = (32'(coef_index) < MAX_TAPS);
                    end
                    else
                    begin
                        cmd.hist_we = 1'b1;
                        head_next   = head_reg + AW'(1);
                        if (32'(fill_reg) < MAX_TAPS)
                            fill_next = fill_reg + CW'(1);
                        p_next     = '0;
                        state_next = S_PHASE;
                    end
                end
            end
            S_PHASE:
            begin
                if (phase_reg == '0)
                begin
                    cmd.acc_clear = 1'b1;
                    m_next        = MW'(p_reg);
                    k_next        = '0;
                    state_next    = S_CALC;
                end
                else
                begin
                    phase_next = phase_adv;
                    p_next     = p_reg + rpr_pkg::UP_W'(1);
                    if (last_pos)
                        state_next = S_IDLE;
                end
            end
            S_CALC:
            begin
                if (m_reg < MW'(t_eff))
                begin
                    cmd.issue = 1'b1;
                    cmd.zero  = (CW'(k_reg) >= fill_reg);
                    m_next    = m_reg + MW'(u_eff);
                    k_next    = k_reg + AW'(1);
                end
                else
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                cmd.out_load = 1'b1;
                cmd.last     = (d_eff > remaining);
                state_next   = S_EMIT;
            end
            S_EMIT:
            begin
                if (status.out_taken)
                begin
                    phase_next = phase_adv;
                    p_next     = p_reg + rpr_pkg::UP_W'(1);
                    state_next = last_pos ? S_IDLE : S_PHASE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State, counters and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            up_reg    <= rpr_pkg::UP_W'(1);
            down_reg  <= rpr_pkg::DOWN_W'(1);
            taps_reg  <= rpr_pkg::TAPS_W'(1);
            head_reg  <= '0;
            fill_reg  <= '0;
            phase_reg <= '0;
            p_reg     <= '0;
            m_reg     <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            fill_reg  <= fill_next;
            phase_reg <= phase_next;
            p_reg     <= p_next;
            m_reg     <= m_next;
            k_reg     <= k_next;
            if (cfg_we)
            begin
                priority if (cfg_index == rpr_pkg::REG_UP_FACTOR)
                    up_reg <= cfg_wdata[rpr_pkg::UP_W-1:0];
                else if (cfg_index == rpr_pkg::REG_DOWN_FACTOR)
                    down_reg <= cfg_wdata;
                else if (cfg_index == rpr_pkg::REG_TAP_COUNT)
                    taps_reg <= cfg_wdata[rpr_pkg::TAPS_W-1:0];
                else
                    up_reg <= up_reg;
            end
        end
    end

endmodule

/* rtl/rpr_check.sv */
// Port-level checker for the resampler, bound to the top level.
module rpr_check (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast
);

    // Input is closed while a result is waiting
    a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready)
        else $error("input open while result pending");

    // A coefficient load leaves the block idle
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser) |=> s_tready)
        else $error("coefficient load did not return to idle");

    // A sample push starts work
    a_push_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && !s_tuser) |=> !s_tready)
        else $error("sample push did not start work");

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("stalled result changed");

endmodule

bind rational_polyphase_resampler rpr_check u_rpr_check (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

/* sim/tb_rational_polyphase_resampler.sv */
// Self-checking testbench for the rational polyphase resampler.
module tb_rational_polyphase_resampler;

    typedef struct {
        logic               op;
        logic [7:0]         idx;
        logic signed [15:0] value;
    } item_t;

    typedef struct {
        logic signed [15:0] sample;
        logic               last;
    } result_t;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_we;
    logic [rpr_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [rpr_pkg::DOWN_W-1:0]    cfg_wdata;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [23:0]                   s_tdata;   // coef_index[7:0], value[23:8]
    logic                          s_tuser;   // opcode
    logic                          m_tvalid;
    logic                          m_tready;
    logic [15:0]                   m_tdata;   // out_sample[15:0]
    logic                          m_tlast;

    rational_polyphase_resampler u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // Predictor state
    logic [rpr_pkg::UP_W-1:0]   up_reg;
    logic [rpr_pkg::DOWN_W-1:0] down_reg;
    logic [rpr_pkg::TAPS_W-1:0] taps_reg;
    logic signed [15:0]         coef_tab [256];
    logic signed [15:0]         hist_ring [256];
    logic [7:0]                 hist_head;
    int unsigned                decim_pos;
    bit                         coef_planned [256];

    item_t   pending_items[$];
    item_t   held_item;
    result_t expected_out[$];
    int      fail_count;
    int      send_idle_pct;
    int      recv_stall_pct;
    int      hold_left;
    bit      hold_req;
    bit      hold_seen;

    // Clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Work out the outputs of one pushed sample
    task automatic resample_push(input logic signed [15:0] x);
        int unsigned u_eff;
        int unsigned d_eff;
        int unsigned t_eff;
        int unsigned k;
        int unsigned m;
        longint      acc;
        longint      q;
        result_t     r;
        int          made;
        u_eff = (up_reg == 0) ? 1 :
                ((up_reg > rpr_pkg::MAX_UP_DEF) ? rpr_pkg::MAX_UP_DEF : up_reg);
        d_eff = (down_reg == 0) ? 1 :
                ((down_reg > rpr_pkg::MAX_DOWN) ? rpr_pkg::MAX_DOWN : down_reg);
        t_eff = (taps_reg > rpr_pkg::MAX_TAPS_DEF) ? rpr_pkg::MAX_TAPS_DEF : taps_reg;
        hist_head = hist_head + 8'd1;
        hist_ring[hist_head] = x;
        made = 0;
        for (int unsigned p = 0; p < u_eff; p++)
        begin
            if (decim_pos == 0)
            begin
                acc = 0;
                k   = 0;
                for (m = p; m < t_eff; m += u_eff)
                begin
                    acc += longint'(coef_tab[m]) * longint'(hist_ring[8'(hist_head - k)]);
                    k++;
                end
                q = (acc + 16384) >>> 15;
                if (q > 32767)
                    q = 32767;
                if (q < -32768)
                    q = -32768;
                r.sample = 16'(q);
                r.last   = 1'b0;
                expected_out.push_back(r);
                made++;
            end
            decim_pos = (decim_pos + 1 >= d_eff) ? 0 : decim_pos + 1;
        end
        if (made > 0)
            expected_out[$].last = 1'b1;
    endtask

    // Driver: offer queued items, predict each one as it is taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= rpr_pkg::OP_PUSH;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (s_tvalid)
            begin
                if (held_item.op == rpr_pkg::OP_LOAD)
                    coef_tab[held_item.idx] = held_item.value;
                else
                    resample_push(held_item.value);
            end
            if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                held_item = pending_items.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {held_item.value, held_item.idx};
                s_tuser  <= held_item.op;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Long receiver hold-off, counted here
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_seen <= 1'b0;
        end
        else if (hold_req != hold_seen)
        begin
            hold_seen <= hold_req;
            hold_left <= 3000;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // Monitor: check each taken result against the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        result_t e;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_out.size() == 0)
                begin
                    $error("unexpected item: out_sample %0d last %0b",
                           $signed(m_tdata), m_tlast);
                    fail_count++;
                end
                else
                begin
                    e = expected_out.pop_front();
                    if (m_tdata !== e.sample)
                    begin
                        $error("out_sample: expected %0d actual %0d", e.sample,
                               $signed(m_tdata));
                        fail_count++;
                    end
                    if (m_tlast !== e.last)
                    begin
                        $error("last: expected %0b actual %0b", e.last, m_tlast);
                        fail_count++;
                    end
                end
            end
            m_tready <= (hold_left == 0 && hold_req == hold_seen)
                        && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic write_reg(input logic [rpr_pkg::CFG_IDX_W-1:0] idx,
                             input int unsigned val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= rpr_pkg::DOWN_W'(val);
        case (idx)
            rpr_pkg::REG_UP_FACTOR:   up_reg   = rpr_pkg::UP_W'(val);
            rpr_pkg::REG_DOWN_FACTOR: down_reg = rpr_pkg::DOWN_W'(val);
            default:                  taps_reg = rpr_pkg::TAPS_W'(val);
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic signed [15:0] rand_value();
        case ($urandom_range(5))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return 16'(int'($urandom_range(64)) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic queue_item(input logic op, input logic [7:0] idx,
                              input logic signed [15:0] value);
        item_t it;
        it.op    = op;
        it.idx   = idx;
        it.value = value;
        if (op == rpr_pkg::OP_LOAD)
            coef_planned[idx] = 1'b1;
        pending_items.push_back(it);
    endtask

    // Load every tap in use that has never been queued for loading
    task automatic cover_taps();
        int unsigned t_eff;
        t_eff = (taps_reg > rpr_pkg::MAX_TAPS_DEF) ? rpr_pkg::MAX_TAPS_DEF : taps_reg;
        for (int i = 0; i < t_eff; i++)
            if (!coef_planned[i])
                queue_item(rpr_pkg::OP_LOAD, 8'(i), rand_value());
    endtask

    // Random pushes with the odd coefficient load mixed in
    task automatic queue_random(input int n);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(9) == 0)
                queue_item(rpr_pkg::OP_LOAD, 8'($urandom), rand_value());
            queue_item(rpr_pkg::OP_PUSH, 8'($urandom), rand_value());
        end
    endtask

    task automatic wait_drained();
        while (pending_items.size() > 0 || s_tvalid || expected_out.size() > 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic set_factors(input int unsigned up, input int unsigned down,
                               input int unsigned taps);
        wait_drained();
        write_reg(rpr_pkg::REG_UP_FACTOR, up);
        write_reg(rpr_pkg::REG_DOWN_FACTOR, down);
        write_reg(rpr_pkg::REG_TAP_COUNT, taps);
        cover_taps();
    endtask

    // Stimulus
    initial
    begin
        fail_count     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = 1'b0;
        up_reg         = 1;
        down_reg       = 1;
        taps_reg       = 1;
        hist_head      = 0;
        decim_pos      = 0;
        for (int i = 0; i < 256; i++)
        begin
            coef_tab[i]     = '0;
            hist_ring[i]    = '0;
            coef_planned[i] = 1'b0;
        end
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset factors, full-scale coefficient, extreme samples
        queue_item(rpr_pkg::OP_LOAD, 8'd0, 16'sh8000);
        queue_item(rpr_pkg::OP_PUSH, 8'd0, 16'sh8000);   // saturates high
        queue_item(rpr_pkg::OP_PUSH, 8'hFF, 16'sh7FFF);
        queue_item(rpr_pkg::OP_LOAD, 8'd0, 16'sh7FFF);
        queue_item(rpr_pkg::OP_PUSH, 8'd0, 16'sh7FFF);
        queue_item(rpr_pkg::OP_PUSH, 8'd0, 16'sh8000);
        queue_item(rpr_pkg::OP_PUSH, 8'd0, 16'sd1);
        queue_item(rpr_pkg::OP_PUSH, 8'd0, -16'sd1);
        queue_item(rpr_pkg::OP_PUSH, 8'd0, 16'sd0);
        queue_item(rpr_pkg::OP_LOAD, 8'd255, 16'sh7FFF);
        // Zero factors act as one, zero taps give zero sums
        set_factors(0, 0, 0);
        for (int i = 0; i < 4; i++)
            queue_item(rpr_pkg::OP_PUSH, 8'($urandom), rand_value());
        // Oversized factors: 32 outputs per push
        set_factors(63, 1, 40);
        queue_random(4);
        send_idle_pct = 80;
        queue_random(6);

        // Random phases
        set_factors(3, 2, 12);
        send_idle_pct = 0;
        queue_random(16);
        set_factors(1, 2047, 8);
        queue_random(10);
        set_factors(2, 3, 511);
        recv_stall_pct = 80;
        queue_random(8);
        set_factors(1, 1, 9);
        recv_stall_pct = 0;
        queue_random(10);
        set_factors(5, 7, 33);
        send_idle_pct  = 35;
        recv_stall_pct = 35;
        queue_random(16);
        // Long hold-off while the sender keeps offering
        set_factors(2, 1, 24);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = ~hold_req;
        queue_random(10);
        // Sender pause until all results are in, then large period shrinks
        set_factors(32, 1024, 256);
        queue_random(6);
        wait_drained();
        write_reg(rpr_pkg::REG_DOWN_FACTOR, 3);
        write_reg(rpr_pkg::REG_TAP_COUNT, 16);
        send_idle_pct  = 35;
        recv_stall_pct = 35;
        queue_random(8);
        set_factors(4, 5, 20);
        send_idle_pct = 80;
        recv_stall_pct = 0;
        queue_random(8);

        wait_drained();
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Timeout
    initial
    begin
        #30_000_000;
        $display("status: fail");
        $finish;
    end
endmodule
